@@ src/dragonfly_min_route_assert.svh @@
// Assertion helpers for the dragonfly minimal route block.
`ifndef DRAGONFLY_MIN_ROUTE_ASSERT_SVH
`define DRAGONFLY_MIN_ROUTE_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define DMR_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre holds -> post holds after the delay given by argument n
`define DMR_ASSERT_DELAY(name, clk, rst, pre, n, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error(msg);

`endif

@@ src/dmr_pkg.sv @@
package dmr_pkg;

   localparam int SW_W     = 15;
   localparam int NODE_W   = 5;
   localparam int DNODE_W  = 4;
   localparam int PORT_W   = 6;
   localparam int MASK_W   = 2;
   localparam int RADIX_W  = 7;
   localparam int LSW_W    = 5;
   localparam int SPG_W    = 6;
   localparam int GRP_W    = 10;
   localparam int HALF_W   = SW_W - 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd16;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd8;

   localparam logic REG_SWITCH_RADIX  = 1'b0;
   localparam logic REG_USE_ALL_PORTS = 1'b1;

   localparam logic [MASK_W-1:0] VC_NONE = 2'b00;
   localparam logic [MASK_W-1:0] VC_0    = 2'b01;
   localparam logic [MASK_W-1:0] VC_1    = 2'b10;
   localparam logic [MASK_W-1:0] VC_BOTH = 2'b11;

   // reciprocal table for small divisors: floor(2^RECIP_SHIFT / d)
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 20;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam int RECIP_DEPTH = 32;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
      20'd0, 20'd0,
      20'(RECIP_ONE / 2),  20'(RECIP_ONE / 3),  20'(RECIP_ONE / 4),  20'(RECIP_ONE / 5),
      20'(RECIP_ONE / 6),  20'(RECIP_ONE / 7),  20'(RECIP_ONE / 8),  20'(RECIP_ONE / 9),
      20'(RECIP_ONE / 10), 20'(RECIP_ONE / 11), 20'(RECIP_ONE / 12), 20'(RECIP_ONE / 13),
      20'(RECIP_ONE / 14), 20'(RECIP_ONE / 15), 20'(RECIP_ONE / 16), 20'(RECIP_ONE / 17),
      20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
      20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
   };

   typedef enum logic [2:0] {
      ROUTE_BAD,
      ROUTE_CORE,
      ROUTE_SELF,
      ROUTE_LOCAL,
      ROUTE_GLOBAL
   } route_kind_type;

   typedef struct packed {
      logic [GRP_W-1:0] grp;
      logic [LSW_W-1:0] lsw;
   } sw_loc_type;

endpackage

@@ src/dragonfly_min_route.sv @@
// Minimal route computation for a dragonfly of switches. One word is taken in every
// cycle (busy is never raised) and its route comes out as a one-cycle rsp_strobe
// pulse with out_port, vc_mask and bad_id; the receiver cannot stall, so results
// must be captured when the strobe is high. The route comes from a seven-stage pipeline:
// group and in-group split by the switches per group, then the global slot split by the
// global ports per switch, each done as a reciprocal multiply with one correction step.
// Topology values derived from switch_radix and use_all_ports are registered after a
// register write and are only read from the second stage on.
`include "dragonfly_min_route_assert.svh"

module dragonfly_min_route
   import dmr_pkg::*;
#(
   parameter int MAX_RADIX = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [SW_W-1:0]       req_current_switch,
   input  logic [NODE_W-1:0]     req_current_node,
   input  logic [SW_W-1:0]       req_dest_switch,
   input  logic [DNODE_W-1:0]    req_dest_node,
   output logic                  rsp_strobe,
   output logic [PORT_W-1:0]     rsp_out_port,
   output logic [MASK_W-1:0]     rsp_vc_mask,
   output logic                  rsp_bad_id,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int RADIX_ALIGNED = MAX_RADIX - (MAX_RADIX % 4);
   localparam int RADIX_CAP     = (RADIX_ALIGNED < 8) ? 8 : RADIX_ALIGNED;
   localparam int LATENCY       = 7;

   function automatic logic [PORT_W-1:0] local_port(
      input logic [LSW_W-1:0]   a,
      input logic [LSW_W-1:0]   b,
      input logic [RADIX_W-1:0] radix,
      input logic [LSW_W-1:0]   cores
   );
      logic [RADIX_W-1:0] a_x, b_x, c_x, port;
      a_x = {2'b00, a};
      b_x = {2'b00, b};
      c_x = {2'b00, cores};
      if (a_x < b_x) begin
         port = radix - (b_x - a_x);
      end else if (a_x == b_x + 7'd1) begin
         port = c_x;
      end else begin
         port = c_x + b_x + 7'd1;
      end
      return port[PORT_W-1:0];
   endfunction

   function automatic logic [GRP_W-1:0] link_slot_grp(
      input logic [GRP_W-1:0] a,
      input logic [GRP_W-1:0] b,
      input logic [GRP_W-1:0] n
   );
      logic [GRP_W:0]   a_x, b_x;
      logic [GRP_W-1:0] slot;
      a_x = {1'b0, a};
      b_x = {1'b0, b};
      if (a_x < b_x) begin
         slot = n - (b - a);
      end else if (a_x == b_x + 11'd1) begin
         slot = '0;
      end else begin
         slot = b + 10'd1;
      end
      return slot;
   endfunction

   // split a switch id into group and switch-in-group; sw = 2*h + b, spg = 2*cores
   function automatic sw_loc_type split_switch(
      input logic [SW_W-1:0]   sw,
      input logic [HALF_W-1:0] q_est,
      input logic [LSW_W-1:0]  cores
   );
      logic [HALF_W-1:0] c_x, rem, q;
      sw_loc_type        loc;
      c_x = {{(HALF_W-LSW_W){1'b0}}, cores};
      rem = sw[SW_W-1:1] - c_x * q_est;
      q   = q_est;
      if (rem >= c_x) begin
         q   = q_est + 14'd1;
         rem = rem - c_x;
      end
      loc.grp = q[GRP_W-1:0];
      loc.lsw = {rem[LSW_W-2:0], sw[0]};
      return loc;
   endfunction

   // ---------------- configuration registers ----------------
   logic [RADIX_W-1:0] radix_cfg_ff;
   logic               use_all_cfg_ff;
   logic               cfg_write;

   assign cfg_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_cfg_ff   <= RADIX_RESET;
         use_all_cfg_ff <= 1'b0;
      end else if (cfg_write) begin
         case (paddr[2])
            REG_SWITCH_RADIX:  radix_cfg_ff   <= pwdata[RADIX_W-1:0];
            REG_USE_ALL_PORTS: use_all_cfg_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (paddr[2])
         REG_SWITCH_RADIX:  prdata[RADIX_W-1:0] = radix_cfg_ff;
         REG_USE_ALL_PORTS: prdata[0]           = use_all_cfg_ff;
         default: ;
      endcase
   end

   // ---------------- derived topology ----------------
   logic [RADIX_W-1:0] radix_al, radix_in, radix_ff;
   logic [LSW_W-1:0]   cores_in, cores_ff, gps_in, gps_ff;
   logic [SPG_W-1:0]   spg_in, spg_ff;
   logic [GRP_W-1:0]   gpg_in, gpg_ff;
   logic [SW_W-1:0]    nsw_in, nsw_ff;
   logic [RECIP_W-1:0] recip_cores_in, recip_cores_ff, recip_gps_in, recip_gps_ff;

   always_comb begin
      radix_al = {radix_cfg_ff[RADIX_W-1:2], 2'b00};
      if (radix_al < RADIX_MIN) begin
         radix_in = RADIX_MIN;
      end else if (radix_al > RADIX_W'(RADIX_CAP)) begin
         radix_in = RADIX_W'(RADIX_CAP);
      end else begin
         radix_in = radix_al;
      end
      cores_in       = radix_in[RADIX_W-1:2];
      spg_in         = radix_in[RADIX_W-1:1];
      gps_in         = cores_in + {{(LSW_W-1){1'b0}}, use_all_cfg_ff};
      gpg_in         = {{(GRP_W-LSW_W){1'b0}}, gps_in} * {{(GRP_W-SPG_W){1'b0}}, spg_in};
      recip_cores_in = RECIP_TABLE[cores_in];
      recip_gps_in   = RECIP_TABLE[gps_in];
      nsw_in         = ({{(SW_W-GRP_W){1'b0}}, gpg_ff} + 15'd1)
                       * {{(SW_W-SPG_W){1'b0}}, spg_ff};
   end

   always_ff @(posedge clock) begin
      radix_ff       <= radix_in;
      cores_ff       <= cores_in;
      spg_ff         <= spg_in;
      gps_ff         <= gps_in;
      gpg_ff         <= gpg_in;
      recip_cores_ff <= recip_cores_in;
      recip_gps_ff   <= recip_gps_in;
      nsw_ff         <= nsw_in;
   end

   // ---------------- pipeline valids ----------------
   logic [LATENCY-1:0] valid_ff;
   logic               accept;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LATENCY-2:0], accept};
      end
   end

   // ---------------- stage 1: capture ----------------
   logic [SW_W-1:0]    s1_cur_sw_ff, s1_dst_sw_ff;
   logic [NODE_W-1:0]  s1_cur_nd_ff;
   logic [DNODE_W-1:0] s1_dst_nd_ff;

   always_ff @(posedge clock) begin
      s1_cur_sw_ff <= req_current_switch;
      s1_cur_nd_ff <= req_current_node;
      s1_dst_sw_ff <= req_dest_switch;
      s1_dst_nd_ff <= req_dest_node;
   end

   // ---------------- stage 2: reciprocal multiply ----------------
   logic [HALF_W+RECIP_W-1:0] prod_c, prod_d;
   logic [HALF_W-1:0]         s2_qc_in, s2_qd_in, s2_qc_ff, s2_qd_ff;
   logic [SW_W-1:0]           s2_cur_sw_ff, s2_dst_sw_ff;
   logic [NODE_W-1:0]         s2_cur_nd_ff;
   logic [DNODE_W-1:0]        s2_dst_nd_ff;

   always_comb begin
      prod_c   = {{RECIP_W{1'b0}}, s1_cur_sw_ff[SW_W-1:1]} * {{HALF_W{1'b0}}, recip_cores_ff};
      prod_d   = {{RECIP_W{1'b0}}, s1_dst_sw_ff[SW_W-1:1]} * {{HALF_W{1'b0}}, recip_cores_ff};
      s2_qc_in = prod_c[HALF_W+RECIP_SHIFT-1:RECIP_SHIFT];
      s2_qd_in = prod_d[HALF_W+RECIP_SHIFT-1:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      s2_qc_ff     <= s2_qc_in;
      s2_qd_ff     <= s2_qd_in;
      s2_cur_sw_ff <= s1_cur_sw_ff;
      s2_cur_nd_ff <= s1_cur_nd_ff;
      s2_dst_sw_ff <= s1_dst_sw_ff;
      s2_dst_nd_ff <= s1_dst_nd_ff;
   end

   // ---------------- stage 3: correction, id checks ----------------
   sw_loc_type         s3_cur_in, s3_dst_in, s3_cur_ff, s3_dst_ff;
   logic               s3_bad_in, s3_bad_ff, s3_core_in, s3_core_ff, s3_self_in, s3_self_ff;
   logic [DNODE_W-1:0] s3_dst_nd_ff;

   always_comb begin
      s3_cur_in  = split_switch(s2_cur_sw_ff, s2_qc_ff, cores_ff);
      s3_dst_in  = split_switch(s2_dst_sw_ff, s2_qd_ff, cores_ff);
      s3_bad_in  = (s2_cur_sw_ff >= nsw_ff) | (s2_dst_sw_ff >= nsw_ff)
                 | (s2_cur_nd_ff > cores_ff) | ({1'b0, s2_dst_nd_ff} >= cores_ff);
      s3_core_in = (s2_cur_nd_ff != cores_ff);
      s3_self_in = (s2_cur_sw_ff == s2_dst_sw_ff);
   end

   always_ff @(posedge clock) begin
      s3_cur_ff    <= s3_cur_in;
      s3_dst_ff    <= s3_dst_in;
      s3_bad_ff    <= s3_bad_in;
      s3_core_ff   <= s3_core_in;
      s3_self_ff   <= s3_self_in;
      s3_dst_nd_ff <= s2_dst_nd_ff;
   end

   // ---------------- stage 4: classify, slots ----------------
   route_kind_type     s4_kind_in, s4_kind_ff;
   logic [GRP_W-1:0]   s4_gp_in, s4_gp_ff;
   logic [PORT_W-1:0]  s4_local_in, s4_local_ff;
   logic [LSW_W-1:0]   s4_cs_ff;
   logic [DNODE_W-1:0] s4_dst_nd_ff;

   always_comb begin
      if (s3_bad_ff) begin
         s4_kind_in = ROUTE_BAD;
      end else if (s3_core_ff) begin
         s4_kind_in = ROUTE_CORE;
      end else if (s3_self_ff) begin
         s4_kind_in = ROUTE_SELF;
      end else if (s3_cur_ff.grp == s3_dst_ff.grp) begin
         s4_kind_in = ROUTE_LOCAL;
      end else begin
         s4_kind_in = ROUTE_GLOBAL;
      end
      s4_gp_in    = link_slot_grp(s3_cur_ff.grp, s3_dst_ff.grp, gpg_ff);
      s4_local_in = local_port(s3_cur_ff.lsw, s3_dst_ff.lsw, radix_ff, cores_ff);
   end

   always_ff @(posedge clock) begin
      s4_kind_ff   <= s4_kind_in;
      s4_gp_ff     <= s4_gp_in;
      s4_local_ff  <= s4_local_in;
      s4_cs_ff     <= s3_cur_ff.lsw;
      s4_dst_nd_ff <= s3_dst_nd_ff;
   end

   // ---------------- stage 5: global slot reciprocal ----------------
   logic [GRP_W+RECIP_W-1:0] prod_g;
   logic [GRP_W-1:0]         s5_q_in, s5_q_ff, s5_gp_ff;
   route_kind_type           s5_kind_ff;
   logic [PORT_W-1:0]        s5_local_ff;
   logic [LSW_W-1:0]         s5_cs_ff;
   logic [DNODE_W-1:0]       s5_dst_nd_ff;

   always_comb begin
      prod_g  = {{RECIP_W{1'b0}}, s4_gp_ff} * {{GRP_W{1'b0}}, recip_gps_ff};
      s5_q_in = prod_g[GRP_W+RECIP_SHIFT-1:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      s5_q_ff      <= s5_q_in;
      s5_gp_ff     <= s4_gp_ff;
      s5_kind_ff   <= s4_kind_ff;
      s5_local_ff  <= s4_local_ff;
      s5_cs_ff     <= s4_cs_ff;
      s5_dst_nd_ff <= s4_dst_nd_ff;
   end

   // ---------------- stage 6: global slot correction ----------------
   logic [GRP_W-1:0]   gps_x, grem_full, gsw_full;
   logic [LSW_W-1:0]   s6_gsw_in, s6_gsw_ff, s6_grem_in, s6_grem_ff;
   route_kind_type     s6_kind_ff;
   logic [PORT_W-1:0]  s6_local_ff;
   logic [LSW_W-1:0]   s6_cs_ff;
   logic [DNODE_W-1:0] s6_dst_nd_ff;

   always_comb begin
      gps_x     = {{(GRP_W-LSW_W){1'b0}}, gps_ff};
      grem_full = s5_gp_ff - s5_q_ff * gps_x;
      gsw_full  = s5_q_ff;
      if (grem_full >= gps_x) begin
         gsw_full  = s5_q_ff + 10'd1;
         grem_full = grem_full - gps_x;
      end
      s6_gsw_in  = gsw_full[LSW_W-1:0];
      s6_grem_in = grem_full[LSW_W-1:0];
   end

   always_ff @(posedge clock) begin
      s6_gsw_ff    <= s6_gsw_in;
      s6_grem_ff   <= s6_grem_in;
      s6_kind_ff   <= s5_kind_ff;
      s6_local_ff  <= s5_local_ff;
      s6_cs_ff     <= s5_cs_ff;
      s6_dst_nd_ff <= s5_dst_nd_ff;
   end

   // ---------------- stage 7: port select, output word ----------------
   logic [PORT_W-1:0]  port_in, rsp_port_ff;
   logic [MASK_W-1:0]  mask_in, rsp_mask_ff;
   logic               bad_in, rsp_bad_ff;
   logic [RADIX_W-1:0] global_sum;

   always_comb begin
      global_sum = {2'b00, cores_ff} + {2'b00, s6_gsw_ff} + {2'b00, s6_grem_ff};
      port_in    = '0;
      mask_in    = VC_NONE;
      bad_in     = 1'b0;
      case (s6_kind_ff)
         ROUTE_BAD: begin
            bad_in = 1'b1;
         end
         ROUTE_CORE: begin
            mask_in = VC_BOTH;
         end
         ROUTE_SELF: begin
            port_in = {2'b00, s6_dst_nd_ff};
            mask_in = VC_0;
         end
         ROUTE_LOCAL: begin
            port_in = s6_local_ff;
            mask_in = VC_1;
         end
         ROUTE_GLOBAL: begin
            if (s6_gsw_ff == s6_cs_ff) begin
               port_in = global_sum[PORT_W-1:0];
            end else begin
               port_in = local_port(s6_cs_ff, s6_gsw_ff, radix_ff, cores_ff);
            end
            mask_in = VC_0;
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_port_ff <= port_in;
      rsp_mask_ff <= mask_in;
      rsp_bad_ff  <= bad_in;
   end

   assign rsp_strobe   = valid_ff[LATENCY-1];
   assign rsp_out_port = rsp_port_ff;
   assign rsp_vc_mask  = rsp_mask_ff;
   assign rsp_bad_id   = rsp_bad_ff;

   // ---------------- assertions ----------------
   `DMR_ASSERT_DELAY(a_word_comes_out, clock, reset, accept, LATENCY, rsp_strobe,
      "accepted word gave no result at the pipeline latency")
   `DMR_ASSERT_IMPLY(a_no_stray_result, clock, reset, rsp_strobe, $past(accept, LATENCY),
      "result strobe without a matching accepted word")
   `DMR_ASSERT_IMPLY(a_bad_fields_zero, clock, reset, rsp_strobe && rsp_bad_id,
      (rsp_vc_mask == VC_NONE) && (rsp_out_port == '0),
      "bad id result carries a port or channel mask")
   `DMR_ASSERT_IMPLY(a_good_has_vc, clock, reset, rsp_strobe && !rsp_bad_id,
      rsp_vc_mask != VC_NONE, "valid route without any virtual channel")

endmodule

@@ sim/tb_dragonfly_min_route.sv @@
`timescale 1ns / 1ps

module tb_dragonfly_min_route;
   import dmr_pkg::*;

   localparam int TB_MAX_RADIX = 64;

   typedef struct {
      logic [PORT_W-1:0] port;
      logic [MASK_W-1:0] vcs;
      logic              bad;
   } route_word_type;

   class route_scoreboard;
      int unsigned radix_reg;
      int unsigned all_ports;
      int unsigned n_cores;
      int unsigned per_group;
      int unsigned gports;
      int unsigned gslots;
      int unsigned n_switches;
      int unsigned radix_eff;
      route_word_type due_q[$];
      int          errors;

      function new();
         radix_reg = RADIX_RESET;
         all_ports = 0;
         errors    = 0;
         refresh();
      endfunction

      function void refresh();
         int unsigned hi;
         hi        = TB_MAX_RADIX & ~3;
         radix_eff = radix_reg & ~3;
         if (hi < RADIX_MIN) hi = RADIX_MIN;
         if (radix_eff < RADIX_MIN) radix_eff = RADIX_MIN;
         if (radix_eff > hi) radix_eff = hi;
         n_cores    = radix_eff / 4;
         per_group  = radix_eff / 2;
         gports     = radix_eff - n_cores - (per_group - 1) - (all_ports != 0 ? 0 : 1);
         gslots     = gports * per_group;
         n_switches = (gslots + 1) * per_group;
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_W-1:0] v);
         if (idx == REG_SWITCH_RADIX) radix_reg = v[RADIX_W-1:0];
         else all_ports = v[0];
         refresh();
      endfunction

      function int unsigned peer_slot(int unsigned a, int unsigned b, int unsigned n);
         if (a < b) return n - (b - a);
         if (a == b + 1) return 0;
         return b + 1;
      endfunction

      function int unsigned intra_port(int unsigned a, int unsigned b);
         if (a < b) return peer_slot(a, b, radix_eff);
         return n_cores + peer_slot(a, b, radix_eff);
      endfunction

      function route_word_type predict(int unsigned cs, int unsigned cn,
                                       int unsigned ds, int unsigned dn);
         route_word_type r;
         int unsigned p, cg, dg, cl, dl, gp, gsw;
         p     = 0;
         r.vcs = VC_NONE;
         r.bad = 1'b0;
         if (cs >= n_switches || ds >= n_switches || cn > n_cores || dn >= n_cores) begin
            r.bad = 1'b1;
         end else if (cn != n_cores) begin
            r.vcs = VC_BOTH;
         end else if (cs == ds) begin
            p     = dn;
            r.vcs = VC_0;
         end else begin
            cg = cs / per_group;
            dg = ds / per_group;
            cl = cs % per_group;
            dl = ds % per_group;
            if (cg == dg) begin
               p     = intra_port(cl, dl);
               r.vcs = VC_1;
            end else begin
               gp  = peer_slot(cg, dg, gslots);
               gsw = gp / gports;
               if (gsw == cl) p = n_cores + gsw + gp % gports;
               else p = intra_port(cl, gsw);
               r.vcs = VC_0;
            end
         end
         r.port = p[PORT_W-1:0];
         return r;
      endfunction

      function void note_word(int unsigned cs, int unsigned cn, int unsigned ds,
                              int unsigned dn);
         due_q.insert(due_q.size(), predict(cs, cn, ds, dn));
      endfunction

      function void check_result(logic [PORT_W-1:0] port, logic [MASK_W-1:0] vcs,
                                 logic bad);
         route_word_type e;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected result port %0d vc %0d bad %0d",
                     $time, port, vcs, bad);
            errors++;
            return;
         end
         e = due_q.pop_front();
         if (port !== e.port) begin
            $display("%0t: out_port expected %0d actual %0d", $time, e.port, port);
            errors++;
         end
         if (vcs !== e.vcs) begin
            $display("%0t: vc_mask expected %0d actual %0d", $time, e.vcs, vcs);
            errors++;
         end
         if (bad !== e.bad) begin
            $display("%0t: bad_id expected %0d actual %0d", $time, e.bad, bad);
            errors++;
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [SW_W-1:0]       req_current_switch = '0;
   logic [NODE_W-1:0]     req_current_node = '0;
   logic [SW_W-1:0]       req_dest_switch = '0;
   logic [DNODE_W-1:0]    req_dest_node = '0;
   logic                  rsp_strobe;
   logic [PORT_W-1:0]     rsp_out_port;
   logic [MASK_W-1:0]     rsp_vc_mask;
   logic                  rsp_bad_id;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   route_scoreboard sb = new();
   bit              burst = 0;

   always #1 clock = ~clock;

   dragonfly_min_route #(.MAX_RADIX(TB_MAX_RADIX)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_current_switch (req_current_switch),
      .req_current_node   (req_current_node),
      .req_dest_switch    (req_dest_switch),
      .req_dest_node      (req_dest_node),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_port       (rsp_out_port),
      .rsp_vc_mask        (rsp_vc_mask),
      .rsp_bad_id         (rsp_bad_id),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_word(req_current_switch, req_current_node, req_dest_switch,
                         req_dest_node);
         if (rsp_strobe)
            sb.check_result(rsp_out_port, rsp_vc_mask, rsp_bad_id);
      end
   end

   function automatic int pick_gap();
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic [SW_W-1:0] cs, input logic [NODE_W-1:0] cn,
                            input logic [SW_W-1:0] ds, input logic [DNODE_W-1:0] dn,
                            input int gap);
      start              <= 1'b1;
      req_current_switch <= cs;
      req_current_node   <= cn;
      req_dest_switch    <= ds;
      req_dest_node      <= dn;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, v);
   endtask

   task automatic set_topology(input int unsigned radix, input int unsigned all);
      drain();
      // let the pipeline empty out before touching the topology
      repeat (10) @(posedge clock);
      csr_write(REG_SWITCH_RADIX, ($urandom & ~32'h7F) | radix);
      csr_write(REG_USE_ALL_PORTS, ($urandom & ~32'h1) | all);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_random_word();
      int unsigned cs, cn, ds, dn, r;
      r = $urandom_range(0, 99);
      if (r < 90) cs = $urandom_range(0, sb.n_switches - 1);
      else cs = $urandom_range(0, 32767);
      r = $urandom_range(0, 99);
      if (r < 60) cn = sb.n_cores;
      else if (r < 85) cn = $urandom_range(0, sb.n_cores - 1);
      else cn = $urandom_range(0, 31);
      r = $urandom_range(0, 99);
      if (r < 25) ds = cs;
      else if (r < 55) ds = (cs / sb.per_group) * sb.per_group
                            + $urandom_range(0, sb.per_group - 1);
      else if (r < 92) ds = $urandom_range(0, sb.n_switches - 1);
      else ds = $urandom_range(0, 32767);
      r = $urandom_range(0, 99);
      if (r < 92) dn = $urandom_range(0, sb.n_cores - 1);
      else dn = $urandom_range(0, 15);
      send_word(SW_W'(cs), NODE_W'(cn), SW_W'(ds), DNODE_W'(dn), pick_gap());
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 48 == 0) burst = ($urandom_range(0, 99) < 25);
         if (i == n / 2) drain();
         send_random_word();
      end
      burst = 0;
   endtask

   task automatic directed_words();
      // reset topology: radix 16, 4 cores, 8 switches per group, 264 switches
      send_word(0, 0, 5, 1, pick_gap());
      send_word(263, 3, 0, 0, pick_gap());
      send_word(10, 4, 10, 0, pick_gap());
      send_word(10, 4, 10, 3, pick_gap());
      send_word(8, 4, 15, 2, pick_gap());
      send_word(15, 4, 8, 2, pick_gap());
      send_word(9, 4, 8, 1, pick_gap());
      send_word(1, 4, 0, 0, pick_gap());
      send_word(0, 4, 7, 0, pick_gap());
      send_word(0, 4, 8, 0, pick_gap());
      send_word(0, 4, 256, 0, pick_gap());
      send_word(263, 4, 0, 3, pick_gap());
      send_word(100, 4, 200, 1, pick_gap());
      send_word(128, 4, 136, 0, pick_gap());
      send_word(264, 4, 0, 0, pick_gap());
      send_word(0, 4, 264, 0, pick_gap());
      send_word(0, 5, 1, 0, pick_gap());
      send_word(0, 4, 1, 4, pick_gap());
      send_word(16384, 4, 1, 1, pick_gap());
      send_word(15'h7FFF, 5'h1F, 15'h7FFF, 4'hF, pick_gap());
      send_word(0, 0, 0, 0, pick_gap());
      send_word(0, 4, 0, 0, pick_gap());
   endtask

   initial begin
      int unsigned radix_list[12] = '{8, 64, 64, 8, 18, 0, 127, 33, 65, 7, 44, 24};
      int unsigned all_list[12]   = '{0, 1, 0, 1, 1, 0, 1, 0, 0, 1, 1, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_words();
      drain();
      random_phase(150);
      for (int k = 0; k < 12; k++) begin
         set_topology(radix_list[k], all_list[k]);
         random_phase(140);
      end
      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/dmr_pkg.sv
src/dragonfly_min_route.sv
sim/tb_dragonfly_min_route.sv
